// ----- rtl/arq_unacked_message_tracker_unit_macros.svh -----
// Assertion macros for the unacked message tracker.
// Used by arq_unacked_message_tracker_unit; needs nothing else.
`ifndef ARQ_UNACKED_MESSAGE_TRACKER_UNIT_MACROS_SVH
`define ARQ_UNACKED_MESSAGE_TRACKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ARQUT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("arqut assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ARQUT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("arqut assertion failed");

`endif

// ----- rtl/arqut_pkg.sv -----
// Shared constants and types of the unacked message tracker.
// Used by the top level and the testbench; depends on nothing.
`default_nettype none

package arqut_pkg;

  localparam int TableDepth = 32;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int PendW      = $clog2(TableDepth + 1);
  localparam int MaxResults = 32;
  localparam int CntW       = $clog2(MaxResults + 1);

  localparam int StampW     = 32;
  localparam int TimeoutW   = 16;
  localparam int KindW      = 2;
  localparam int IdW        = 5;
  localparam int CountOutW  = 6;

  localparam logic [TimeoutW-1:0] TimeoutReset = 16'd2;

  typedef enum logic [KindW-1:0] {
    KindSend = 2'd0,
    KindAck  = 2'd1,
    KindData = 2'd2,
    KindTick = 2'd3
  } kind_e;

  typedef enum logic [KindW-1:0] {
    ResAssigned = 2'd0,
    ResDataAck  = 2'd1,
    ResRetx     = 2'd2,
    ResNoted    = 2'd3
  } res_kind_e;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StScan  = 3'b010,
    StFlush = 3'b100
  } state_e;

endpackage

`default_nettype wire

// ----- rtl/arq_unacked_message_tracker_unit.sv -----
// Top level of the selective-repeat unacked message tracker.
// Depends on arqut_pkg, arqut_ram and the assertion macro header.
//
// Usage:
//   Input beats (kind_i, msg_id_i) arrive on a valid/stall channel and are taken
//   when in_valid_i is high and in_stall_o is low. Result beats leave on a
//   valid/stall channel through one output register and are taken when
//   out_valid_o is high and out_stall_i is low.
//   Send, ack and data beats are handled in the cycle they are accepted; their
//   single result is registered and shows in the next cycle, and a new beat can
//   be taken every cycle as long as the output register drains.
//   A tick beat walks the stamp memory one entry per cycle while the walk is
//   not paused (see below); no input beat is taken until the tick is done.
//   The walk is set by the single read port of the stamp RAM.
//   Each due id is held back one step so that the final retransmit beat can
//   carry last_o; a tick with nothing due yields one "tick done" beat.
//   When the receiver stalls, the output register holds its beat. The walk
//   goes on until it finds a due id while another one is already held; it
//   then pauses on that entry. No input beat is taken meanwhile.
//   The timeout register is written through cfg_valid_i/cfg_data_i; it is
//   always ready and should only be written while the block is idle.
//   Reset clears pending and seen marks, the id counter, the pending count,
//   the time counter, and sets the timeout to 2. Stamps are not cleared; they
//   are only read for ids whose pending mark is set.
`default_nettype none

`include "arq_unacked_message_tracker_unit_macros.svh"

module arq_unacked_message_tracker_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Configuration channel.
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [arqut_pkg::TimeoutW-1:0]     cfg_data_i,
  // Input channel.
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [arqut_pkg::KindW-1:0]        kind_i,
  input  wire logic [arqut_pkg::IdW-1:0]          msg_id_i,
  // Result channel.
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic      [arqut_pkg::KindW-1:0]        result_kind_o,
  output logic      [arqut_pkg::IdW-1:0]          result_id_o,
  output logic                                    is_duplicate_o,
  output logic      [arqut_pkg::CountOutW-1:0]    pending_count_o,
  output logic                                    last_o
);

  localparam int Depth = arqut_pkg::TableDepth;
  localparam int IdxW  = arqut_pkg::IdxW;

  // Control state.
  arqut_pkg::state_e                 state_q, state_d;
  logic [Depth-1:0]                  pend_q, pend_d;
  logic [Depth-1:0]                  seen_q, seen_d;
  logic [IdxW-1:0]                   next_id_q, next_id_d;
  logic [arqut_pkg::PendW-1:0]       pend_total_q, pend_total_d;
  logic [arqut_pkg::StampW-1:0]      now_q, now_d;
  logic [arqut_pkg::TimeoutW-1:0]    timeout_q;
  logic [IdxW-1:0]                   scan_idx_q, scan_idx_d;
  logic                              held_valid_q, held_valid_d;
  logic [IdxW-1:0]                   held_id_q, held_id_d;
  logic [arqut_pkg::CntW-1:0]        cnt_q, cnt_d;
  logic                              out_valid_q, out_valid_d;

  // Output payload registers.
  logic [arqut_pkg::KindW-1:0]       res_kind_q;
  logic [arqut_pkg::IdW-1:0]         res_id_q;
  logic                              res_dup_q;
  logic [arqut_pkg::CountOutW-1:0]   res_cnt_q;
  logic                              res_last_q;

  // Result being loaded this cycle.
  logic                              push;
  logic [arqut_pkg::KindW-1:0]       push_kind;
  logic [arqut_pkg::IdW-1:0]         push_id;
  logic                              push_dup;
  logic                              push_last;

  // Stamp memory port signals.
  logic                              ram_we;
  logic [IdxW-1:0]                   ram_waddr;
  logic [arqut_pkg::StampW-1:0]      ram_wdata;
  logic [IdxW-1:0]                   ram_raddr;
  logic [arqut_pkg::StampW-1:0]      ram_rdata;

  logic                              can_push;
  logic                              in_acc;
  logic [IdxW-1:0]                   idx_in;
  logic                              id_ok;
  logic [arqut_pkg::StampW-1:0]      age;
  logic                              due;
  logic                              step_ok;
  logic                              scan_end;
  logic                              scan_we;
  logic                              tick_acc;

  arqut_ram #(
    .Width(arqut_pkg::StampW),
    .Depth(Depth)
  ) u_stamps (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // The output register can take a new beat if it is empty or being drained.
  assign can_push   = !out_valid_q || !out_stall_i;
  assign in_acc     = in_valid_i && (state_q == arqut_pkg::StIdle) && can_push;
  assign in_stall_o = !((state_q == arqut_pkg::StIdle) && can_push);

  assign idx_in = IdxW'(msg_id_i);
  assign id_ok  = (32'(msg_id_i) < 32'(Depth));

  // During the walk, ram_rdata holds the stamp of scan_idx_q. The age is taken
  // modulo 2^32, and no more than MaxResults ids are named per tick.
  assign age      = now_q - ram_rdata;
  assign due      = pend_q[scan_idx_q] &&
                    (age >= arqut_pkg::StampW'(timeout_q)) &&
                    (cnt_q < arqut_pkg::CntW'(arqut_pkg::MaxResults));
  // A due id displaces the held one, which then has to go out right now.
  assign step_ok  = !(due && held_valid_q) || can_push;
  assign scan_end = (scan_idx_q == IdxW'(Depth - 1));

  always_comb begin
    state_d      = state_q;
    pend_d       = pend_q;
    seen_d       = seen_q;
    next_id_d    = next_id_q;
    pend_total_d = pend_total_q;
    now_d        = now_q;
    scan_idx_d   = scan_idx_q;
    held_valid_d = held_valid_q;
    held_id_d    = held_id_q;
    cnt_d        = cnt_q;

    push      = 1'b0;
    push_kind = arqut_pkg::ResNoted;
    push_id   = '0;
    push_dup  = 1'b0;
    push_last = 1'b1;

    ram_we    = 1'b0;
    ram_waddr = scan_idx_q;
    ram_wdata = now_q;
    ram_raddr = '0;

    unique case (state_q)
      arqut_pkg::StIdle: begin
        if (in_acc) begin
          unique case (arqut_pkg::kind_e'(kind_i))
            arqut_pkg::KindSend: begin
              ram_we    = 1'b1;
              ram_waddr = next_id_q;
              if (!pend_q[next_id_q]) begin
                pend_d[next_id_q] = 1'b1;
                pend_total_d      = pend_total_q + 1'b1;
              end
              next_id_d = (next_id_q == IdxW'(Depth - 1)) ? '0 : next_id_q + 1'b1;
              push      = 1'b1;
              push_kind = arqut_pkg::ResAssigned;
              push_id   = arqut_pkg::IdW'(next_id_q);
            end
            arqut_pkg::KindAck: begin
              if (id_ok && pend_q[idx_in]) begin
                pend_d[idx_in] = 1'b0;
                pend_total_d   = pend_total_q - 1'b1;
              end
              push      = 1'b1;
              push_kind = arqut_pkg::ResNoted;
              push_id   = msg_id_i;
            end
            arqut_pkg::KindData: begin
              if (id_ok) begin
                seen_d[idx_in] = 1'b1;
              end
              push      = 1'b1;
              push_kind = arqut_pkg::ResDataAck;
              push_id   = msg_id_i;
              push_dup  = id_ok && seen_q[idx_in];
            end
            arqut_pkg::KindTick: begin
              now_d        = now_q + 1'b1;
              scan_idx_d   = '0;
              held_valid_d = 1'b0;
              cnt_d        = '0;
              state_d      = arqut_pkg::StScan;
            end
            default: begin
              state_d = arqut_pkg::StIdle;
            end
          endcase
        end
      end
      arqut_pkg::StScan: begin
        if (step_ok) begin
          if (due) begin
            ram_we       = 1'b1;
            held_id_d    = scan_idx_q;
            held_valid_d = 1'b1;
            cnt_d        = cnt_q + 1'b1;
            if (held_valid_q) begin
              push      = 1'b1;
              push_kind = arqut_pkg::ResRetx;
              push_id   = arqut_pkg::IdW'(held_id_q);
              push_last = 1'b0;
            end
          end
          if (scan_end) begin
            state_d = arqut_pkg::StFlush;
          end else begin
            scan_idx_d = scan_idx_q + 1'b1;
            ram_raddr  = scan_idx_q + 1'b1;
          end
        end else begin
          // Paused: keep the stamp of the current entry on the read port.
          ram_raddr = scan_idx_q;
        end
      end
      arqut_pkg::StFlush: begin
        if (can_push) begin
          push    = 1'b1;
          state_d = arqut_pkg::StIdle;
          if (held_valid_q) begin
            push_kind = arqut_pkg::ResRetx;
            push_id   = arqut_pkg::IdW'(held_id_q);
          end
        end
      end
      default: begin
        state_d = arqut_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (push) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= arqut_pkg::StIdle;
      pend_q       <= '0;
      seen_q       <= '0;
      next_id_q    <= '0;
      pend_total_q <= '0;
      now_q        <= '0;
      timeout_q    <= arqut_pkg::TimeoutReset;
      scan_idx_q   <= '0;
      held_valid_q <= 1'b0;
      held_id_q    <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pend_q       <= pend_d;
      seen_q       <= seen_d;
      next_id_q    <= next_id_d;
      pend_total_q <= pend_total_d;
      now_q        <= now_d;
      scan_idx_q   <= scan_idx_d;
      held_valid_q <= held_valid_d;
      held_id_q    <= held_id_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  // Payload is only loaded together with a new beat, so it needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      res_kind_q <= push_kind;
      res_id_q   <= push_id;
      res_dup_q  <= push_dup;
      res_cnt_q  <= arqut_pkg::CountOutW'(pend_total_d);
      res_last_q <= push_last;
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = res_kind_q;
  assign result_id_o     = res_id_q;
  assign is_duplicate_o  = res_dup_q;
  assign pending_count_o = res_cnt_q;
  assign last_o          = res_last_q;

  assign scan_we  = ram_we && (state_q == arqut_pkg::StScan);
  assign tick_acc = in_acc && (kind_i == arqut_pkg::KindTick);

  // The pending count always matches the number of pending marks.
  `ARQUT_ASSERT_IMP(a_pend_total, clk_i, rst_ni, 1'b1, 32'(pend_total_q) == $countones(pend_q))
  // The walk never writes the entry it is reading, so no forwarding is needed.
  `ARQUT_ASSERT_IMP(a_no_rw_clash, clk_i, rst_ni, scan_we, ram_waddr != ram_raddr)
  // No input beat is taken while a tick is being worked on.
  `ARQUT_ASSERT_IMP(a_busy_stall, clk_i, rst_ni, state_q != arqut_pkg::StIdle, in_stall_o)
  // An accepted tick always starts a walk.
  `ARQUT_ASSERT_NEXT(a_tick_walk, clk_i, rst_ni, tick_acc, state_q == arqut_pkg::StScan)

endmodule

`default_nettype wire

// ----- rtl/arqut_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; depends on nothing.
`default_nettype none

module arqut_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for arq_unacked_message_tracker_unit.
// Depends only on arqut_pkg and the unit under test; beats are checked
// against a cycle-free model of the unacked message ledger.
`timescale 1ns / 1ps

module tb;

  // One result beat as the block should produce it.
  typedef struct {
    arqut_pkg::res_kind_e                kind;
    logic [arqut_pkg::IdW-1:0]           id;
    logic                                dup;
    logic [arqut_pkg::CountOutW-1:0]     count;
    logic                                last;
  } tracker_beat_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                cfg_valid_i = 1'b0;
  logic                                cfg_ready_o;
  logic [arqut_pkg::TimeoutW-1:0]      cfg_data_i = '0;
  logic                                in_valid_i = 1'b0;
  logic                                in_stall_o;
  logic [arqut_pkg::KindW-1:0]         kind_i = '0;
  logic [arqut_pkg::IdW-1:0]           msg_id_i = '0;
  logic                                out_valid_o;
  logic                                out_stall_i = 1'b0;
  logic [arqut_pkg::KindW-1:0]         result_kind_o;
  logic [arqut_pkg::IdW-1:0]           result_id_o;
  logic                                is_duplicate_o;
  logic [arqut_pkg::CountOutW-1:0]     pending_count_o;
  logic                                last_o;

  // Ledger of unacked messages, mirrored from what the block should hold.
  logic                             ledger_pending [arqut_pkg::TableDepth] = '{default: 1'b0};
  logic [arqut_pkg::StampW-1:0]     ledger_stamp [arqut_pkg::TableDepth];
  logic                             ledger_seen [arqut_pkg::TableDepth] = '{default: 1'b0};
  logic [arqut_pkg::IdW-1:0]        ledger_next_id = '0;
  logic [arqut_pkg::CountOutW-1:0]  ledger_count = '0;
  logic [arqut_pkg::StampW-1:0]     ledger_now = '0;
  logic [arqut_pkg::TimeoutW-1:0]   ledger_timeout = arqut_pkg::TimeoutReset;

  tracker_beat_t         owed_beats [$];
  int                    mismatch_count = 0;

  // Flow control knobs: chance in percent of an idle cycle on each side.
  int                    sender_idle_pct = 0;
  int                    receiver_stall_pct = 0;
  int                    hold_left = 0;

  arq_unacked_message_tracker_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .msg_id_i        (msg_id_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_kind_o   (result_kind_o),
    .result_id_o     (result_id_o),
    .is_duplicate_o  (is_duplicate_o),
    .pending_count_o (pending_count_o),
    .last_o          (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one accepted beat to the ledger and queues the results it owes.
  function automatic void ledger_apply(arqut_pkg::kind_e k, logic [arqut_pkg::IdW-1:0] id);
    logic [arqut_pkg::IdW-1:0] a;
    int n;
    n = 0;
    case (k)
      arqut_pkg::KindSend: begin
        a = ledger_next_id;
        // A send over a still pending id only restamps it.
        if (!ledger_pending[a]) begin
          ledger_pending[a] = 1'b1;
          ledger_count++;
        end
        ledger_stamp[a] = ledger_now;
        ledger_next_id = arqut_pkg::IdW'((int'(a) + 1) % arqut_pkg::TableDepth);
        owed_beats.push_back('{arqut_pkg::ResAssigned, a, 1'b0, ledger_count, 1'b1});
      end
      arqut_pkg::KindAck: begin
        if (int'(id) < arqut_pkg::TableDepth && ledger_pending[id]) begin
          ledger_pending[id] = 1'b0;
          ledger_count--;
        end
        owed_beats.push_back('{arqut_pkg::ResNoted, id, 1'b0, ledger_count, 1'b1});
      end
      arqut_pkg::KindData: begin
        a = '0;
        if (int'(id) < arqut_pkg::TableDepth) begin
          a[0] = ledger_seen[id];
          ledger_seen[id] = 1'b1;
        end
        owed_beats.push_back('{arqut_pkg::ResDataAck, id, a[0], ledger_count, 1'b1});
      end
      default: begin
        // Time moves first, then the table is scanned from id zero upward.
        ledger_now++;
        for (int i = 0; i < arqut_pkg::TableDepth && n < arqut_pkg::MaxResults; i++) begin
          if (ledger_pending[i] &&
              (ledger_now - ledger_stamp[i]) >= arqut_pkg::StampW'(ledger_timeout)) begin
            ledger_stamp[i] = ledger_now;
            owed_beats.push_back('{arqut_pkg::ResRetx, arqut_pkg::IdW'(i), 1'b0,
                                   ledger_count, 1'b0});
            n++;
          end
        end
        if (n == 0) begin
          owed_beats.push_back('{arqut_pkg::ResNoted, '0, 1'b0, ledger_count, 1'b1});
        end else begin
          owed_beats[owed_beats.size() - 1].last = 1'b1;
        end
      end
    endcase
  endfunction

  task automatic flag_mismatch(string what);
    $display("MISMATCH at %0t ns: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Offers one input beat after a random gap and holds it until taken.
  // Valid is left high; the next beat or settle() decides what follows.
  task automatic push_beat(arqut_pkg::kind_e k, logic [arqut_pkg::IdW-1:0] id);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    kind_i = k;
    msg_id_i = id;
    do @(posedge clk_i); while (in_stall_o);
    ledger_apply(k, id);
  endtask

  // Stops offering beats, waits for every owed result, then lets the tick
  // walk run out before anything else happens.
  task automatic settle(int extra);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (owed_beats.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_timeout(logic [arqut_pkg::TimeoutW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    ledger_timeout = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Receiver side: a long hold-off takes priority over random stalls.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else begin
      out_stall_i = ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Every result beat taken by the receiver is checked against the oldest
  // owed beat.
  always @(posedge clk_i) begin : check_results
    tracker_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (owed_beats.size() == 0) begin
        flag_mismatch($sformatf("result beat kind %0d id %0d with none owed",
                                result_kind_o, result_id_o));
      end else begin
        want = owed_beats.pop_front();
        if (result_kind_o !== want.kind)
          flag_mismatch($sformatf("result_kind %0d, want %0d", result_kind_o, want.kind));
        if (result_id_o !== want.id)
          flag_mismatch($sformatf("result_id %0d, want %0d", result_id_o, want.id));
        if (is_duplicate_o !== want.dup)
          flag_mismatch($sformatf("is_duplicate %0b, want %0b", is_duplicate_o, want.dup));
        if (pending_count_o !== want.count)
          flag_mismatch($sformatf("pending_count %0d, want %0d",
                                  pending_count_o, want.count));
        if (last_o !== want.last)
          flag_mismatch($sformatf("last %0b, want %0b", last_o, want.last));
      end
    end
  end

  // Every operation at the reset timeout, then a timeout of one and the largest
  // timeout. Ids on send and tick beats must be ignored.
  task automatic test_directed_ops();
    push_beat(arqut_pkg::KindTick, 5'd17);   // nothing pending: tick done only
    push_beat(arqut_pkg::KindSend, 5'd31);   // takes id 0
    push_beat(arqut_pkg::KindSend, 5'd0);    // takes id 1
    push_beat(arqut_pkg::KindAck, 5'd0);
    push_beat(arqut_pkg::KindAck, 5'd0);     // ack of an id no longer pending
    push_beat(arqut_pkg::KindAck, 5'd31);    // ack of an id never sent
    push_beat(arqut_pkg::KindData, 5'd5);
    push_beat(arqut_pkg::KindData, 5'd5);    // duplicate
    push_beat(arqut_pkg::KindData, 5'd31);
    push_beat(arqut_pkg::KindData, 5'd0);
    push_beat(arqut_pkg::KindTick, 5'd0);    // id 1 is one tick old: not yet due
    push_beat(arqut_pkg::KindTick, 5'd31);   // id 1 reaches the timeout
    push_beat(arqut_pkg::KindAck, 5'd1);
    settle(40);
    write_timeout(16'd1);
    push_beat(arqut_pkg::KindSend, 5'd10);
    push_beat(arqut_pkg::KindTick, 5'd3);
    push_beat(arqut_pkg::KindTick, 5'd28);   // restamped id is due again one tick later
    settle(40);
    write_timeout(16'hFFFF);
    push_beat(arqut_pkg::KindTick, 5'd0);
    push_beat(arqut_pkg::KindAck, 5'd2);
    settle(40);
  endtask

  // Timeout zero with a full table: the receiver holds off for a long time
  // while sends keep coming, so the output backs up and the input stalls.
  // Sends wrap over pending ids, and one tick names all of them.
  task automatic test_full_table_backpressure();
    write_timeout(16'd0);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    @(negedge clk_i);
    hold_left = 300;
    repeat (arqut_pkg::TableDepth + 8)
      push_beat(arqut_pkg::KindSend,
                arqut_pkg::IdW'($urandom_range(arqut_pkg::TableDepth - 1)));
    push_beat(arqut_pkg::KindTick, 5'd9);
    push_beat(arqut_pkg::KindData, 5'd31);
    push_beat(arqut_pkg::KindTick, 5'd0);
    push_beat(arqut_pkg::KindAck, 5'd31);
    push_beat(arqut_pkg::KindTick, 5'd31);
    // The sender waits here until every owed beat has come back.
    settle(40);
  endtask

  // Random beats under one timeout and one idling profile. Most acks name
  // a pending id so that the table keeps turning over.
  task automatic test_random_traffic(int idle_pct, int stall_pct,
                                     logic [arqut_pkg::TimeoutW-1:0] timeout, int beats);
    int r;
    arqut_pkg::kind_e k;
    logic [arqut_pkg::IdW-1:0] id;
    write_timeout(timeout);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (beats) begin
      r = $urandom_range(99);
      if (r < 35) k = arqut_pkg::KindSend;
      else if (r < 65) k = arqut_pkg::KindAck;
      else if (r < 85) k = arqut_pkg::KindData;
      else k = arqut_pkg::KindTick;
      id = arqut_pkg::IdW'($urandom_range(arqut_pkg::TableDepth - 1));
      if (k == arqut_pkg::KindAck && $urandom_range(3) != 0) begin
        for (int j = 0; j < arqut_pkg::TableDepth; j++) begin
          if (ledger_pending[(int'(id) + j) % arqut_pkg::TableDepth]) begin
            id = arqut_pkg::IdW'((int'(id) + j) % arqut_pkg::TableDepth);
            break;
          end
        end
      end
      push_beat(k, id);
    end
    settle(40);
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_ops();
    test_full_table_backpressure();
    test_random_traffic(0, 0, 16'd1, 60);
    test_random_traffic(84, 0, 16'd3, 60);
    test_random_traffic(0, 84, 16'd0, 60);
    test_random_traffic(28, 28, 16'hFFFF, 35);
    test_random_traffic(0, 0, arqut_pkg::TimeoutW'($urandom_range(2, 8)), 35);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Watchdog expired with %0d result beats still owed", owed_beats.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/arqut_pkg.sv
rtl/arqut_ram.sv
rtl/arq_unacked_message_tracker_unit.sv
test/tb.sv
